FILE: design/vhd_pkg.sv
// Shared constants, types and the arctangent table of the vector heading block.
package vhd_pkg;

    // Defaults for the top-level parameters.
    localparam int COORD_BITS_DEF      = 16;
    localparam int CORDIC_STAGES_DEF   = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 8;

    // Fixed-point format of the datapath.
    localparam int PRE_SHIFT = 16;   // coordinates scaled up by 2^PRE_SHIFT
    localparam int ACC_FRAC  = 20;   // fraction bits of the angle accumulator
    localparam int TABLE_LEN = 24;   // entries in the arctangent table
    localparam int Z_BITS    = 28;   // signed accumulator, covers about +/-128 degrees

    // Quadrant of the folded vector; the heading base is 90 degrees per step.
    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } quad_t;

    // Side information that travels with each request down the pipeline.
    typedef struct packed {
        quad_t quad;
        logic  zero;
    } side_t;

    // atan(2^-idx) in degrees, scaled by 2^ACC_FRAC.
    function automatic logic [Z_BITS-1:0] atan_deg(input int idx);
        logic [Z_BITS-1:0] val;
        case (idx)
            0:       val = Z_BITS'(47185920);
            1:       val = Z_BITS'(27855475);
            2:       val = Z_BITS'(14718068);
            3:       val = Z_BITS'(7471121);
            4:       val = Z_BITS'(3750058);
            5:       val = Z_BITS'(1876857);
            6:       val = Z_BITS'(938658);
            7:       val = Z_BITS'(469357);
            8:       val = Z_BITS'(234682);
            9:       val = Z_BITS'(117342);
            10:      val = Z_BITS'(58671);
            11:      val = Z_BITS'(29335);
            12:      val = Z_BITS'(14668);
            13:      val = Z_BITS'(7334);
            14:      val = Z_BITS'(3667);
            15:      val = Z_BITS'(1833);
            16:      val = Z_BITS'(917);
            17:      val = Z_BITS'(458);
            18:      val = Z_BITS'(229);
            19:      val = Z_BITS'(115);
            20:      val = Z_BITS'(57);
            21:      val = Z_BITS'(29);
            22:      val = Z_BITS'(14);
            23:      val = Z_BITS'(7);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

FILE: design/vhd_cordic_stage.sv
// One registered CORDIC vectoring stage with its own valid/ready handshake.
module vhd_cordic_stage #(
    parameter int W         = 35,
    parameter int STAGE_IDX = 0
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              valid_in,
    output logic                              ready_in,
    input  logic signed [W-1:0]               u_in,
    input  logic signed [W-1:0]               v_in,
    input  logic signed [vhd_pkg::Z_BITS-1:0] z_in,
    input  vhd_pkg::side_t                    side_in,
    output logic                              valid_out,
    input  logic                              ready_out,
    output logic signed [W-1:0]               u_out,
    output logic signed [W-1:0]               v_out,
    output logic signed [vhd_pkg::Z_BITS-1:0] z_out,
    output vhd_pkg::side_t                    side_out
);

    localparam logic signed [vhd_pkg::Z_BITS-1:0] ATAN = vhd_pkg::atan_deg(STAGE_IDX);

    logic                              valid_reg;
    logic signed [W-1:0]               u_reg, u_next;
    logic signed [W-1:0]               v_reg, v_next;
    logic signed [vhd_pkg::Z_BITS-1:0] z_reg, z_next;
    vhd_pkg::side_t                    side_reg;
    logic signed [W-1:0]               u_sh, v_sh;

    assign ready_in = !valid_reg || ready_out;

    // Floor shifts; rotate toward the x axis.
    always_comb begin
        u_sh = u_in >>> STAGE_IDX;
        v_sh = v_in >>> STAGE_IDX;
        if (v_in[W-1]) begin
            u_next = u_in - v_sh;
            v_next = v_in + u_sh;
            z_next = z_in - ATAN;
        end else begin
            u_next = u_in + v_sh;
            v_next = v_in - u_sh;
            z_next = z_in + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_in) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_in && valid_in) begin
            u_reg    <= u_next;
            v_reg    <= v_next;
            z_reg    <= z_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign u_out     = u_reg;
    assign v_out     = v_reg;
    assign z_out     = z_reg;
    assign side_out  = side_reg;

endmodule

FILE: design/vector_heading_degrees.sv
// Top level: heading in degrees of a signed vector through a pipelined CORDIC.
//
//  channel | ports                               | direction | content
//  --------+-------------------------------------+-----------+---------------------------
//  input   | s_valid, s_ready, s_dx, s_dy        | in        | signed coordinate difference
//  result  | m_valid, m_ready, m_angle,          | out       | heading [0,360) in fixed
//          | m_zero_vector                       |           | point, zero-vector flag
//
// The path is registered in order: fold, one register per CORDIC stage, round,
// output; a request can enter every cycle, set by one add per stage, unless a full pipeline is stalled on m_ready.
// Reset (aresetn low at a clock edge) clears all valid bits; payload registers keep
// whatever they held. Each stage holds its request while the next one is full and
// stalled, so a stall on m_ready backs up stage by stage and empty slots collapse.
module vector_heading_degrees #(
    parameter int COORD_BITS      = vhd_pkg::COORD_BITS_DEF,
    parameter int CORDIC_STAGES   = vhd_pkg::CORDIC_STAGES_DEF,
    parameter int ANGLE_FRAC_BITS = vhd_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_BITS-1:0]  s_dx,
    input  logic signed [COORD_BITS-1:0]  s_dy,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [9+ANGLE_FRAC_BITS-1:0]  m_angle,
    output logic                          m_zero_vector
);

    // Datapath width: sign, one bit for negating the most negative input, the
    // pre-scale, and two bits of CORDIC gain.
    localparam int W         = COORD_BITS + vhd_pkg::PRE_SHIFT + 3;
    localparam int ZB        = vhd_pkg::Z_BITS;
    localparam int AW        = 9 + ANGLE_FRAC_BITS;
    localparam int RND_SHIFT = vhd_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int N         = CORDIC_STAGES;

    localparam logic signed [ZB-1:0] Z_MAX = ZB'(90 * (1 << vhd_pkg::ACC_FRAC));
    localparam logic [ZB-1:0]        HALF  = ZB'(1) << (RND_SHIFT - 1);
    localparam logic [AW-1:0]        BASE_90    = AW'(90) << ANGLE_FRAC_BITS;
    localparam logic [AW-1:0]        BASE_180   = AW'(180) << ANGLE_FRAC_BITS;
    localparam logic [AW-1:0]        BASE_270   = AW'(270) << ANGLE_FRAC_BITS;
    localparam logic [AW-1:0]        ANGLE_FULL = AW'(360) << ANGLE_FRAC_BITS;

    // ---------------------------------------------------------------
    // Fold stage: pick the quadrant and map the vector into it.
    // ---------------------------------------------------------------
    logic                 fold_valid_reg;
    logic                 fold_ready;
    logic signed [W-1:0]  fold_u_reg, fold_u_next;
    logic signed [W-1:0]  fold_v_reg, fold_v_next;
    vhd_pkg::side_t       fold_side_reg, fold_side_next;
    logic signed [W-1:0]  xe, ye;

    logic                 pipe_valid [0:N];
    logic                 pipe_ready [0:N];
    logic signed [W-1:0]  pipe_u     [0:N];
    logic signed [W-1:0]  pipe_v     [0:N];
    logic signed [ZB-1:0] pipe_z     [0:N];
    vhd_pkg::side_t       pipe_side  [0:N];

    assign fold_ready = !fold_valid_reg || pipe_ready[0];
    assign s_ready    = fold_ready;

    always_comb begin
        xe = W'(s_dx);
        ye = W'(s_dy);
        fold_side_next.zero = (s_dx == '0) && (s_dy == '0);
        if (s_dx > 0 && s_dy >= 0) begin
            fold_side_next.quad = vhd_pkg::QUAD_0;
            fold_u_next = xe;
            fold_v_next = ye;
        end else if (s_dx <= 0 && s_dy > 0) begin
            fold_side_next.quad = vhd_pkg::QUAD_90;
            fold_u_next = ye;
            fold_v_next = -xe;
        end else if (s_dx < 0 && s_dy <= 0) begin
            fold_side_next.quad = vhd_pkg::QUAD_180;
            fold_u_next = -xe;
            fold_v_next = -ye;
        end else begin
            fold_side_next.quad = vhd_pkg::QUAD_270;
            fold_u_next = -ye;
            fold_v_next = xe;
        end
        // Pre-scale for fraction headroom in the shifts.
        fold_u_next = fold_u_next <<< vhd_pkg::PRE_SHIFT;
        fold_v_next = fold_v_next <<< vhd_pkg::PRE_SHIFT;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_valid_reg <= 1'b0;
        end else if (fold_ready) begin
            fold_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (fold_ready && s_valid) begin
            fold_u_reg    <= fold_u_next;
            fold_v_reg    <= fold_v_next;
            fold_side_reg <= fold_side_next;
        end
    end

    assign pipe_valid[0] = fold_valid_reg;
    assign pipe_u[0]     = fold_u_reg;
    assign pipe_v[0]     = fold_v_reg;
    assign pipe_z[0]     = '0;
    assign pipe_side[0]  = fold_side_reg;

    // ---------------------------------------------------------------
    // CORDIC vectoring: one registered stage per iteration.
    // ---------------------------------------------------------------
    for (genvar i = 0; i < N; i++) begin : g_stage
        vhd_cordic_stage #(
            .W         (W),
            .STAGE_IDX (i)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .valid_in  (pipe_valid[i]),
            .ready_in  (pipe_ready[i]),
            .u_in      (pipe_u[i]),
            .v_in      (pipe_v[i]),
            .z_in      (pipe_z[i]),
            .side_in   (pipe_side[i]),
            .valid_out (pipe_valid[i+1]),
            .ready_out (pipe_ready[i+1]),
            .u_out     (pipe_u[i+1]),
            .v_out     (pipe_v[i+1]),
            .z_out     (pipe_z[i+1]),
            .side_out  (pipe_side[i+1])
        );
    end

    // ---------------------------------------------------------------
    // Round stage: clamp the accumulated angle to [0, 90] and round half up.
    // The final u and v carry no further information and are dropped here.
    // ---------------------------------------------------------------
    logic                 rnd_valid_reg;
    logic                 rnd_ready;
    logic [AW-1:0]        rnd_frac_reg, rnd_frac_next;
    vhd_pkg::side_t       rnd_side_reg;
    logic signed [ZB-1:0] z_clamped;
    logic [ZB-1:0]        z_rounded;
    logic                 out_ready;

    assign rnd_ready     = !rnd_valid_reg || out_ready;
    assign pipe_ready[N] = rnd_ready;

    always_comb begin
        if (pipe_z[N][ZB-1]) begin
            z_clamped = '0;
        end else if (pipe_z[N] > Z_MAX) begin
            z_clamped = Z_MAX;
        end else begin
            z_clamped = pipe_z[N];
        end
        z_rounded     = (ZB'(unsigned'(z_clamped)) + HALF) >> RND_SHIFT;
        rnd_frac_next = z_rounded[AW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rnd_valid_reg <= 1'b0;
        end else if (rnd_ready) begin
            rnd_valid_reg <= pipe_valid[N];
        end
    end

    always_ff @(posedge aclk) begin
        if (rnd_ready && pipe_valid[N]) begin
            rnd_frac_reg <= rnd_frac_next;
            rnd_side_reg <= pipe_side[N];
        end
    end

    // ---------------------------------------------------------------
    // Output stage: add the quadrant base, wrap 360 to 0, force the zero vector.
    // ---------------------------------------------------------------
    logic          out_valid_reg;
    logic [AW-1:0] out_angle_reg, out_angle_next;
    logic          out_zero_reg;
    logic [AW-1:0] base;
    logic [AW-1:0] angle_sum;

    assign out_ready = !out_valid_reg || m_ready;

    always_comb begin
        case (rnd_side_reg.quad)
            vhd_pkg::QUAD_0:   base = '0;
            vhd_pkg::QUAD_90:  base = BASE_90;
            vhd_pkg::QUAD_180: base = BASE_180;
            vhd_pkg::QUAD_270: base = BASE_270;
            default:           base = '0;
        endcase
        angle_sum = base + rnd_frac_reg;
        if (rnd_side_reg.zero || angle_sum >= ANGLE_FULL) begin
            out_angle_next = '0;
        end else begin
            out_angle_next = angle_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= rnd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && rnd_valid_reg) begin
            out_angle_reg <= out_angle_next;
            out_zero_reg  <= rnd_side_reg.zero;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_angle       = out_angle_reg;
    assign m_zero_vector = out_zero_reg;

`ifndef SYNTHESIS
    // Heading stays below a full turn.
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_angle < ANGLE_FULL)
        else $error("heading out of range");

    // Zero vector always reports angle 0.
    a_zero_angle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_vector |-> m_angle == '0)
        else $error("zero vector with nonzero heading");

    // A zero request lands in the fold stage with its flag set.
    a_fold_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_dx == '0 && s_dy == '0
        |=> fold_valid_reg && fold_side_reg.zero)
        else $error("zero vector lost in fold stage");

    // Rounded fraction never exceeds 90 degrees.
    a_frac_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rnd_valid_reg |-> rnd_frac_reg <= BASE_90)
        else $error("rounded angle above 90 degrees");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
`endif

endmodule
